// ----- rtl/ccmn_pkg.sv -----
// Package: shared types and constants for the certificate-compression negotiator.
`timescale 1ns / 1ps
package ccmn_pkg;

  localparam int unsigned MaskW   = 3;
  localparam logic [7:0]  LenMin  = 8'd2;
  localparam logic [7:0]  LenMax  = 8'd254;
  localparam logic [7:0]  PosMax  = 8'd255;

  localparam logic [1:0] MethodNone   = 2'd0;
  localparam logic [1:0] MethodZlib   = 2'd1;
  localparam logic [1:0] MethodBrotli = 2'd2;
  localparam logic [1:0] MethodZstd   = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_TRUNC   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] selected_method;
    logic       selection_updated;
  } result_t;

endpackage

// ----- rtl/ccmn_if.sv -----
// Interfaces: input byte channel, result channel and configuration write channel.
`timescale 1ns / 1ps
interface ccmn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccmn_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] selected_method;
  logic       selection_updated;
  modport source (output valid, output status, output selected_method,
                  output selection_updated, input ready);
  modport sink   (input valid, input status, input selected_method,
                  input selection_updated, output ready);
endinterface

interface ccmn_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] enabled_methods;
  modport source (output valid, output enabled_methods, input ready);
  modport sink   (input valid, input enabled_methods, output ready);
endinterface

// ----- rtl/ccmn_in_stage.sv -----
// Input register stage: captures one byte transfer and holds it until parsed.
`timescale 1ns / 1ps
module ccmn_in_stage
  import ccmn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ccmn_in_if.sink     in_i,
  input  logic        advance_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d          = 1'b1;
      item_d.data_byte = in_i.data_byte;
      item_d.last_byte = in_i.last_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/ccmn_parse.sv -----
// Parser: list length check, 16-bit entry assembly, mask match and selection store.
`timescale 1ns / 1ps
module ccmn_parse
  import ccmn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  item_t            item_i,
  input  logic [MaskW-1:0] mask_i,
  output result_t          result_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] high_q, high_d;
  logic       match_q, match_d;
  logic [1:0] pend_q, pend_d;
  logic       bad_q, bad_d;
  logic [1:0] sel_q, sel_d;
  logic [7:0] b;
  logic [1:0] bit_idx;

  assign b       = item_i.data_byte;
  assign bit_idx = b[1:0] - 2'd1;

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    high_d   = high_q;
    match_d  = match_q;
    pend_d   = pend_q;
    bad_d    = bad_q;
    sel_d    = sel_q;
    result_o = '{status: STATUS_OK, selected_method: sel_q, selection_updated: 1'b0};

    if (fire_i) begin
      if (mask_i != '0) begin
        if (pos_q == 8'd0) begin
          len_d = b;
          bad_d = (b < LenMin) || (b > LenMax) || b[0];
        end else if (!bad_q && (pos_q <= len_q)) begin
          if (pos_q[0]) begin
            high_d = b;
          end else if ((high_q == 8'd0) && (b >= 8'(MethodZlib)) &&
                       (b <= 8'(MethodZstd)) && !match_q) begin
            if (mask_i[bit_idx]) begin
              match_d = 1'b1;
              pend_d  = b[1:0];
            end
          end
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + 8'd1;
        end
        if (item_i.last_byte) begin
          if (bad_d) begin
            result_o.status = STATUS_BAD_LEN;
          end else if (pos_q < len_d) begin
            result_o.status = STATUS_TRUNC;
          end else begin
            sel_d                      = match_d ? pend_d : MethodNone;
            result_o.selection_updated = 1'b1;
          end
          result_o.selected_method = sel_d;
        end
      end
      if (item_i.last_byte) begin
        pos_d   = '0;
        len_d   = '0;
        high_d  = '0;
        match_d = 1'b0;
        pend_d  = MethodNone;
        bad_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      high_q  <= '0;
      match_q <= 1'b0;
      pend_q  <= MethodNone;
      bad_q   <= 1'b0;
      sel_q   <= MethodNone;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      high_q  <= high_d;
      match_q <= match_d;
      pend_q  <= pend_d;
      bad_q   <= bad_d;
      sel_q   <= sel_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_byte |=> pos_q == 8'd0 && !match_q && !bad_q)
    else $error("parse state not cleared after last byte");
  a_match_has_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> pend_q != MethodNone)
    else $error("match latched without a method");
  a_sel_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && item_i.last_byte) |=> $stable(sel_q))
    else $error("stored selection changed outside a last byte");
  a_update_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.selection_updated |-> result_o.status == STATUS_OK)
    else $error("selection updated with a failing status");
`endif

endmodule

// ----- rtl/cert_compress_method_negotiator_core.sv -----
// Top level: certificate-compression method negotiator, receive side.
`timescale 1ns / 1ps
// Takes one extension body byte per transfer on in_i, one byte per cycle
// while out_o takes its results: a byte is held in the input register, then
// passes through the parser into the result register that drives out_o. Only
// a byte marked last_byte produces a result on out_o; it carries the status,
// the stored selection after this extension, and whether the selection was
// written. Input stalls only while a result waits on out_o and the input
// register holds a byte. enabled_methods is written on cfg_i, which is
// always ready; write it only while no extension is in flight.
module cert_compress_method_negotiator_core
  import ccmn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ccmn_in_if.sink     in_i,
  ccmn_out_if.source  out_o,
  ccmn_cfg_if.sink    cfg_i
);

  logic [MaskW-1:0] mask_q, mask_d;
  logic             stage_valid;
  item_t            stage_item;
  logic             advance;
  result_t          result;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;
  logic             emit;

  assign cfg_i.ready = 1'b1;
  assign mask_d      = (cfg_i.valid && cfg_i.ready) ? cfg_i.enabled_methods : mask_q;

  assign advance = stage_valid && (!out_valid_q || out_o.ready);
  assign emit    = advance && stage_item.last_byte;

  ccmn_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  ccmn_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (stage_item),
    .mask_i   (mask_q),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_res_d   = result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = 2'(out_res_q.status);
  assign out_o.selected_method   = out_res_q.selected_method;
  assign out_o.selection_updated = out_res_q.selection_updated;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !emit)
    else $error("pending result overwritten");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result not presented after last byte");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> stage_valid && out_valid_q && !out_o.ready)
    else $error("input stalled without a full result register");
`endif

endmodule
